/* src/tac_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, codes, reset values and types of the throttle assist controller.
package tac_pkg;

  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned DUTY_W       = 8;
  localparam int unsigned RAMP_W       = 16;
  localparam int unsigned LVL_W        = 3;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned MEDIAN_DEPTH = 3;
  localparam int unsigned CNT_DEPTH_W  = 2;

  localparam int unsigned TOP_LEVEL_DEF      = 5;
  localparam int unsigned ADC_FULL_SCALE_DEF = 1023;

  // Level mix times median times ceiling.
  localparam int unsigned PROD_W = LVL_W + RAMP_W + SAMPLE_W + DUTY_W;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BRAKE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERROR  = 2'd2;

  typedef enum logic [2:0] {
    REG_ADC_LOW  = 3'd0,
    REG_ADC_HIGH = 3'd1,
    REG_FLOOR    = 3'd2,
    REG_CEILING  = 3'd3,
    REG_RAMP     = 3'd4
  } reg_idx_t;

  localparam int unsigned RAMP_RST_INT = 2000;

  localparam logic [SAMPLE_W-1:0] ADC_LOW_RST  = 10'd164;
  localparam logic [SAMPLE_W-1:0] ADC_HIGH_RST = 10'd900;
  localparam logic [DUTY_W-1:0]   FLOOR_RST    = 8'd40;
  localparam logic [DUTY_W-1:0]   CEILING_RST  = 8'd224;
  localparam logic [RAMP_W-1:0]   RAMP_RST     = RAMP_W'(RAMP_RST_INT);
  localparam logic [RAMP_W-1:0]   TICKS_RST    =
    (RAMP_RST_INT + 1 > (1 << RAMP_W) - 1) ? {RAMP_W{1'b1}} : RAMP_W'(RAMP_RST_INT + 1);

  typedef struct packed {
    logic                start;
    logic                ramp;
    logic [LVL_W-1:0]    lvl_before;
    logic [LVL_W-1:0]    lvl_now;
    logic [RAMP_W-1:0]   span_old;
    logic [RAMP_W-1:0]   span_new;
    logic [RAMP_W-1:0]   ramp_len;
    logic [SAMPLE_W-1:0] median;
    logic [DUTY_W-1:0]   ceiling;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic              nonzero;
    logic [PROD_W-1:0] quotient;
  } arith_rsp_t;

  function automatic logic [SAMPLE_W-1:0] median3(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b,
                                                  input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] mid;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    mid = (hi < c) ? hi : c;
    return (lo > mid) ? lo : mid;
  endfunction

endpackage

/* src/tac_window.sv */
`timescale 1ns / 1ps
// Three-tap window of accepted throttle samples and its median.
module tac_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [tac_pkg::SAMPLE_W-1:0]  sample,
  output logic [tac_pkg::SAMPLE_W-1:0]  median
);
  import tac_pkg::*;

  logic [SAMPLE_W-1:0]    w0_r;
  logic [SAMPLE_W-1:0]    w1_r;
  logic [SAMPLE_W-1:0]    w2_r;
  logic [CNT_DEPTH_W-1:0] count_r;
  logic [SAMPLE_W:0]      pair_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push && (count_r < CNT_DEPTH_W'(MEDIAN_DEPTH))) begin
      count_r <= count_r + 1'b1;
    end
  end

  // The taps hold no meaning until written, so they carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      w0_r <= sample;
      w1_r <= w0_r;
      w2_r <= w1_r;
    end
  end

  assign pair_sum = {1'b0, w0_r} + {1'b0, w1_r};

  always_comb begin
    case (count_r)
      2'd1:    median = w0_r;
      2'd2:    median = pair_sum[SAMPLE_W:1];
      2'd3:    median = median3(w0_r, w1_r, w2_r);
      default: median = '0;
    endcase
  end

endmodule

/* src/tac_arith.sv */
`timescale 1ns / 1ps
// Bit-serial multiply chain and restoring divider that turn a median into a raw duty.
module tac_arith #(
  parameter int unsigned TOP_LEVEL      = tac_pkg::TOP_LEVEL_DEF,
  parameter int unsigned ADC_FULL_SCALE = tac_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tac_pkg::arith_req_t req,
  output tac_pkg::arith_rsp_t rsp
);
  import tac_pkg::*;

  localparam int unsigned SCALE = ADC_FULL_SCALE * TOP_LEVEL;
  localparam int unsigned DEN_W = $clog2(SCALE + 1) + RAMP_W;
  localparam int unsigned MIX_W = LVL_W + RAMP_W;
  localparam int unsigned CNT_W = $clog2(PROD_W);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_LVL  = 5'b00010,
    A_MED  = 5'b00100,
    A_CEIL = 5'b01000,
    A_DIV  = 5'b10000
  } arith_state_t;

  arith_state_t        state_r;
  arith_state_t        state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [PROD_W-1:0]   acc_r;
  logic [PROD_W-1:0]   mcand_r;
  logic [MIX_W-1:0]    mcb_r;
  logic [SAMPLE_W-1:0] mpl_r;
  logic [LVL_W-1:0]    mplb_r;
  logic [SAMPLE_W-1:0] med_r;
  logic [DUTY_W-1:0]   ceil_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic                nonzero_r;
  logic                done_r;

  logic [PROD_W-1:0]   add_a;
  logic [PROD_W-1:0]   add_b;
  logic [PROD_W-1:0]   acc_sum;
  logic [DEN_W:0]      shifted;
  logic [DEN_W:0]      diff;
  logic                ge;
  logic                last;

  assign last    = (cnt_r == '0);
  assign add_a   = mpl_r[0] ? mcand_r : '0;
  // The second operand only takes part while the two levels are weighted.
  assign add_b   = ((state_r == A_LVL) && mplb_r[0]) ? PROD_W'(mcb_r) : '0;
  assign acc_sum = acc_r + add_a + add_b;
  assign shifted = {rem_r, acc_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE:  if (req.start) state_nxt = A_LVL;
      A_LVL:   if (last) state_nxt = A_MED;
      A_MED:   if (last) state_nxt = A_CEIL;
      A_CEIL:  if (last) state_nxt = A_DIV;
      A_DIV:   if (last) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == A_DIV) && last;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          acc_r   <= '0;
          mcand_r <= req.ramp ? PROD_W'(req.span_old) : '0;
          mcb_r   <= req.ramp ? MIX_W'(req.span_new) : MIX_W'(1);
          mpl_r   <= SAMPLE_W'(req.lvl_before);
          mplb_r  <= req.lvl_now;
          med_r   <= req.median;
          ceil_r  <= req.ceiling;
          den_r   <= DEN_W'(SCALE) * (req.ramp ? DEN_W'(req.ramp_len) : DEN_W'(1));
          cnt_r   <= CNT_W'(LVL_W - 1);
        end
      end
      A_LVL: begin
        mcb_r  <= mcb_r << 1;
        mplb_r <= mplb_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
        if (last) begin
          acc_r   <= '0;
          mcand_r <= acc_sum;
          mpl_r   <= med_r;
          cnt_r   <= CNT_W'(SAMPLE_W - 1);
        end else begin
          acc_r   <= acc_sum;
          mcand_r <= mcand_r << 1;
          mpl_r   <= mpl_r >> 1;
        end
      end
      A_MED: begin
        cnt_r <= cnt_r - 1'b1;
        if (last) begin
          acc_r   <= '0;
          mcand_r <= acc_sum;
          mpl_r   <= SAMPLE_W'(ceil_r);
          cnt_r   <= CNT_W'(DUTY_W - 1);
        end else begin
          acc_r   <= acc_sum;
          mcand_r <= mcand_r << 1;
          mpl_r   <= mpl_r >> 1;
        end
      end
      A_CEIL: begin
        acc_r   <= acc_sum;
        mcand_r <= mcand_r << 1;
        mpl_r   <= mpl_r >> 1;
        cnt_r   <= cnt_r - 1'b1;
        if (last) begin
          rem_r     <= '0;
          nonzero_r <= (acc_sum != '0);
          cnt_r     <= CNT_W'(PROD_W - 1);
        end
      end
      A_DIV: begin
        // The product shifts out at the top while quotient bits enter at the bottom.
        acc_r <= {acc_r[PROD_W-2:0], ge};
        rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp.done     = done_r;
  assign rsp.nonzero  = nonzero_r;
  assign rsp.quotient = acc_r;

endmodule

/* src/throttle_assist_controller_unit.sv */
`timescale 1ns / 1ps
// Top level of the throttle assist controller: registers, tick control and result stage.
//
// One input transfer per control tick carries the throttle sample, the up and down
// presses and the brake lever. Each accepted item yields exactly one result transfer
// with the duty, brake drive, LED, mode and assist level.
// An item in detect mode with a valid sample runs through the bit-serial arithmetic:
// the shift-add multiplier (21 steps), then the 37-step restoring divider, before
// the result is handed over to the output register. Other items skip the arithmetic
// and pass from acceptance straight to the finish state and the output register.
// One item is worked on at a time; in_tready rises again once the result sits in the
// output register, so the next item is taken while that result waits.
// If the receiver stalls, the result is held in the output register and at most one
// further item is finished and parked until the register frees up.
// Configuration registers sit on an APB-style port at byte addresses 0 to 16 and
// should be written only while no item is in flight.
// Synchronous reset restores the register defaults, level one, detect mode and an
// empty sample window; no clearing pass is needed.
module throttle_assist_controller_unit #(
  parameter int unsigned TOP_LEVEL      = tac_pkg::TOP_LEVEL_DEF,
  parameter int unsigned ADC_FULL_SCALE = tac_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [9:0] throttle_sample, [10] up_press, [11] down_press, [12] brake_applied
  input  logic [tac_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [7:0] pwm_duty, [8] brake_drive, [9] led_on, [11:10] mode, [14:12] speed_level
  output logic [tac_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tac_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tac_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tac_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import tac_pkg::*;

  localparam logic [LVL_W-1:0] TOP_L = LVL_W'(TOP_LEVEL);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } ctrl_state_t;

  ctrl_state_t         state_r;
  ctrl_state_t         state_nxt;

  logic [SAMPLE_W-1:0] adc_low_r;
  logic [SAMPLE_W-1:0] adc_high_r;
  logic [DUTY_W-1:0]   floor_r;
  logic [DUTY_W-1:0]   ceil_r;
  logic [RAMP_W-1:0]   ramp_r;

  logic [MODE_W-1:0]   mode_r;
  logic [LVL_W-1:0]    lvl_now_r;
  logic [LVL_W-1:0]    lvl_before_r;
  logic [RAMP_W-1:0]   ticks_r;
  logic                refpos_r;
  logic                compute_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  logic                accept;
  logic [SAMPLE_W-1:0] sample;
  logic                up;
  logic                down;
  logic                brake;
  logic                pressed;
  logic [LVL_W-1:0]    lvl_nxt;
  logic                entry_pos;
  logic [MODE_W-1:0]   want;
  logic                in_range;
  logic                go_compute;
  logic [MODE_W-1:0]   mode_nxt;
  logic                refpos_nxt;

  logic                out_free;
  logic [DUTY_W-1:0]   duty;
  logic [SAMPLE_W-1:0] median;
  logic                ramp_on;
  arith_req_t          req;
  arith_rsp_t          rsp;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_low_r  <= ADC_LOW_RST;
      adc_high_r <= ADC_HIGH_RST;
      floor_r    <= FLOOR_RST;
      ceil_r     <= CEILING_RST;
      ramp_r     <= RAMP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ADC_LOW:  adc_low_r  <= cfg_pwdata[SAMPLE_W-1:0];
        REG_ADC_HIGH: adc_high_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_FLOOR:    floor_r    <= cfg_pwdata[DUTY_W-1:0];
        REG_CEILING:  ceil_r     <= cfg_pwdata[DUTY_W-1:0];
        REG_RAMP:     ramp_r     <= cfg_pwdata[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ADC_LOW:  cfg_prdata = CFG_DW'(adc_low_r);
      REG_ADC_HIGH: cfg_prdata = CFG_DW'(adc_high_r);
      REG_FLOOR:    cfg_prdata = CFG_DW'(floor_r);
      REG_CEILING:  cfg_prdata = CFG_DW'(ceil_r);
      REG_RAMP:     cfg_prdata = CFG_DW'(ramp_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Tick decisions, all taken on the accepted item
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign sample    = in_tdata[SAMPLE_W-1:0];
  assign up        = in_tdata[SAMPLE_W];
  assign down      = in_tdata[SAMPLE_W+1];
  assign brake     = in_tdata[SAMPLE_W+2];
  assign pressed   = up ^ down;

  always_comb begin
    lvl_nxt = lvl_now_r;
    if (up && !down && (lvl_now_r < TOP_L)) begin
      lvl_nxt = lvl_now_r + 1'b1;
    end else if (down && !up && (lvl_now_r != '0)) begin
      lvl_nxt = lvl_now_r - 1'b1;
    end
    if (lvl_nxt > TOP_L) begin
      lvl_nxt = TOP_L;
    end
  end

  assign entry_pos = (floor_r != '0) && (lvl_nxt != '0) && (ceil_r != '0);
  assign want      = brake ? MODE_BRAKE : MODE_DETECT;
  assign in_range  = (sample >= adc_low_r) && (sample <= adc_high_r);

  always_comb begin
    mode_nxt   = mode_r;
    refpos_nxt = refpos_r;
    go_compute = 1'b0;
    if (mode_r != MODE_ERROR) begin
      if (want != mode_r) begin
        mode_nxt   = want;
        refpos_nxt = entry_pos;
      end else if (mode_r == MODE_DETECT) begin
        if (!in_range) begin
          mode_nxt   = MODE_ERROR;
          refpos_nxt = entry_pos;
        end else begin
          go_compute = 1'b1;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = go_compute ? S_START : S_FINISH;
      S_START:  state_nxt = S_WAIT;
      S_WAIT:   if (rsp.done) state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_DETECT;
      lvl_now_r    <= LVL_W'(1);
      lvl_before_r <= LVL_W'(1);
      ticks_r      <= TICKS_RST;
      refpos_r     <= 1'b1;
      compute_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        lvl_now_r <= lvl_nxt;
        if (pressed) begin
          lvl_before_r <= lvl_now_r;
          ticks_r      <= '0;
        end else if (ticks_r != {RAMP_W{1'b1}}) begin
          ticks_r <= ticks_r + 1'b1;
        end
        mode_r    <= mode_nxt;
        refpos_r  <= refpos_nxt;
        compute_r <= go_compute;
      end else if ((state_r == S_WAIT) && rsp.done) begin
        refpos_r <= rsp.nonzero;
      end
    end
  end

  tac_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept && go_compute),
    .sample (sample),
    .median (median)
  );

  // The ramp runs while the tick count has not passed the ramp length.
  assign ramp_on = (ramp_r != '0) && (ticks_r <= ramp_r);

  always_comb begin
    req.start      = (state_r == S_START);
    req.ramp       = ramp_on;
    req.lvl_before = lvl_before_r;
    req.lvl_now    = lvl_now_r;
    req.span_old   = ramp_r - ticks_r;
    req.span_new   = ticks_r;
    req.ramp_len   = ramp_r;
    req.median     = median;
    req.ceiling    = ceil_r;
  end

  tac_arith #(
    .TOP_LEVEL      (TOP_LEVEL),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // The floor is tested first, so with a floor above the ceiling a quotient below the floor yields the floor.
  always_comb begin
    duty = floor_r;
    if (compute_r) begin
      if (rsp.quotient < PROD_W'(floor_r)) begin
        duty = floor_r;
      end else if (rsp.quotient > PROD_W'(ceil_r)) begin
        duty = ceil_r;
      end else begin
        duty = rsp.quotient[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FINISH) && out_free) begin
      out_data_r <= {1'b0, lvl_now_r, mode_r, refpos_r, (mode_r == MODE_BRAKE), duty};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* src/tac_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the throttle assist controller and their bind.
module tac_checker #(
  parameter int unsigned TOP_LEVEL = tac_pkg::TOP_LEVEL_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [tac_pkg::OUT_W-1:0] out_tdata
);
  import tac_pkg::*;

  // A result stalled by the receiver must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Only one item is in flight: after a transfer in, the input closes.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input open right after a transfer");

  a_brake_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8] == (out_tdata[11:10] == MODE_BRAKE)))
    else $error("brake drive disagrees with mode");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:12] <= TOP_LEVEL))
    else $error("assist level above top level");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind throttle_assist_controller_unit tac_checker #(
  .TOP_LEVEL (TOP_LEVEL)
) u_tac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
